@@ hw/rtl/pmd_pkg.sv @@
// ----------------------------------------------------------------------------
// Polyphase matrix deinterleave package
// Field widths, register map and the metadata record that travels with each
// element through the pipeline.
// ----------------------------------------------------------------------------
package pmd_pkg;

    localparam int ELEM_W  = 64;
    localparam int ROW_W   = 12;
    localparam int COL_W   = 12;
    localparam int CHUNK_W = 14;
    localparam int OFFS_W  = 10;
    localparam int CFG_W   = 13;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // Register index, taken from paddr[2].
    localparam logic REG_ROW_COUNT    = 1'b0;
    localparam logic REG_COLUMN_COUNT = 1'b1;

    typedef struct packed {
        logic [ELEM_W-1:0] element;
        logic [ROW_W-1:0]  dest_row;
        logic [COL_W-1:0]  dest_col;
        logic              end_of_matrix;
    } pmd_meta_t;

    // Load enables of the four pipeline stages.
    typedef struct packed {
        logic a;
        logic b;
        logic c;
        logic r;
    } pmd_stage_en_t;

endpackage

@@ hw/rtl/pmd_if.sv @@
// ----------------------------------------------------------------------------
// Stream interfaces
// Valid/ready channels for the input element and the deinterleaved result.
// ----------------------------------------------------------------------------
interface pmd_in_if
    import pmd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [ELEM_W-1:0] element_bits;

    modport source (output valid, output element_bits, input ready);
    modport sink   (input valid, input element_bits, output ready);
endinterface

interface pmd_out_if
    import pmd_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [ELEM_W-1:0]  element_out;
    logic [ROW_W-1:0]   dest_row;
    logic [COL_W-1:0]   dest_col;
    logic [CHUNK_W-1:0] dest_chunk;
    logic [OFFS_W-1:0]  dest_offset;
    logic               end_of_matrix;

    modport source (output valid, output element_out, output dest_row, output dest_col,
                    output dest_chunk, output dest_offset, output end_of_matrix,
                    input ready);
    modport sink   (input valid, input element_out, input dest_row, input dest_col,
                    input dest_chunk, input dest_offset, input end_of_matrix,
                    output ready);
endinterface

@@ hw/rtl/pmd_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// Configuration registers
// APB register file for the matrix dimensions, plus the clamped dimensions
// used by the datapath.
// ----------------------------------------------------------------------------
module pmd_cfg_regs
    import pmd_pkg::*;
#(
    parameter int MAX_DIM = 4096,
    parameter int DIM_W   = 13
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [DIM_W-1:0]      rows,
    output logic [DIM_W-1:0]      cols
);

    logic [CFG_W-1:0] row_count_reg;
    logic [CFG_W-1:0] row_count_next;
    logic [CFG_W-1:0] column_count_reg;
    logic [CFG_W-1:0] column_count_next;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb
    begin
        row_count_next    = row_count_reg;
        column_count_next = column_count_reg;
        if (wr_en)
        begin
            unique case (paddr[2])
                REG_ROW_COUNT:    row_count_next    = pwdata[CFG_W-1:0];
                REG_COLUMN_COUNT: column_count_next = pwdata[CFG_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= CFG_W'(1);
            column_count_reg <= CFG_W'(1);
        end
        else
        begin
            row_count_reg    <= row_count_next;
            column_count_reg <= column_count_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (paddr[2])
            REG_ROW_COUNT:    prdata = APB_DATA_W'(row_count_reg);
            REG_COLUMN_COUNT: prdata = APB_DATA_W'(column_count_reg);
            default:          prdata = '0;
        endcase
    end

    // A zero dimension counts as one, and anything above MAX_DIM is clamped.
    always_comb
    begin
        if (row_count_reg == '0)
            rows = DIM_W'(1);
        else if (32'(row_count_reg) > 32'(MAX_DIM))
            rows = DIM_W'(MAX_DIM);
        else
            rows = DIM_W'(row_count_reg);

        if (column_count_reg == '0)
            cols = DIM_W'(1);
        else if (32'(column_count_reg) > 32'(MAX_DIM))
            cols = DIM_W'(MAX_DIM);
        else
            cols = DIM_W'(column_count_reg);
    end

endmodule

@@ hw/rtl/pmd_addr_gen.sv @@
// ----------------------------------------------------------------------------
// Source position counters and polyphase address
// Tracks the source row and column and registers the destination row and
// column of each accepted element.
// ----------------------------------------------------------------------------
module pmd_addr_gen
    import pmd_pkg::*;
#(
    parameter int DIM_W = 13,
    parameter int CNT_W = 12
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic              load,
    input  logic [ELEM_W-1:0] element_bits,
    input  logic [DIM_W-1:0]  rows,
    input  logic [DIM_W-1:0]  cols,
    output pmd_meta_t         meta_a,
    output logic [CNT_W-1:0]  dr_a,
    output logic [CNT_W-1:0]  dc_a
);

    logic [CNT_W-1:0]  src_row_reg;
    logic [CNT_W-1:0]  src_row_next;
    logic [CNT_W-1:0]  src_col_reg;
    logic [CNT_W-1:0]  src_col_next;
    logic [CNT_W-1:0]  cur_row;
    logic [CNT_W-1:0]  cur_col;
    logic [DIM_W:0]    rows_p1;
    logic [DIM_W:0]    cols_p1;
    logic [DIM_W-1:0]  dr_full;
    logic [DIM_W-1:0]  dc_full;
    logic [CNT_W+ROW_W-1:0] dr_ext;
    logic [CNT_W+COL_W-1:0] dc_ext;
    logic              row_last;
    logic              col_last;
    pmd_meta_t         meta_next;

    // A counter left beyond a shrunken dimension restarts at zero.
    always_comb
    begin
        cur_row = (DIM_W'(src_row_reg) >= rows) ? '0 : src_row_reg;
        cur_col = (DIM_W'(src_col_reg) >= cols) ? '0 : src_col_reg;
    end

    assign row_last = (DIM_W'(cur_row) + DIM_W'(1)) == rows;
    assign col_last = (DIM_W'(cur_col) + DIM_W'(1)) == cols;

    // Odd positions move to the second half, which starts at ceil(dim/2).
    assign rows_p1 = {1'b0, rows} + (DIM_W+1)'(1);
    assign cols_p1 = {1'b0, cols} + (DIM_W+1)'(1);
    assign dr_full = DIM_W'(cur_row >> 1) + (cur_row[0] ? rows_p1[DIM_W:1] : '0);
    assign dc_full = DIM_W'(cur_col >> 1) + (cur_col[0] ? cols_p1[DIM_W:1] : '0);
    assign dr_ext  = {{ROW_W{1'b0}}, dr_full[CNT_W-1:0]};
    assign dc_ext  = {{COL_W{1'b0}}, dc_full[CNT_W-1:0]};

    always_comb
    begin
        meta_next.element       = element_bits;
        meta_next.dest_row      = dr_ext[ROW_W-1:0];
        meta_next.dest_col      = dc_ext[COL_W-1:0];
        meta_next.end_of_matrix = row_last && col_last;
    end

    always_comb
    begin
        src_row_next = src_row_reg;
        src_col_next = src_col_reg;
        if (accept)
        begin
            if (col_last)
            begin
                src_col_next = '0;
                src_row_next = row_last ? '0 : cur_row + CNT_W'(1);
            end
            else
            begin
                src_col_next = cur_col + CNT_W'(1);
                src_row_next = cur_row;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_row_reg <= '0;
            src_col_reg <= '0;
        end
        else
        begin
            src_row_reg <= src_row_next;
            src_col_reg <= src_col_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            meta_a <= meta_next;
            dr_a   <= dr_full[CNT_W-1:0];
            dc_a   <= dc_full[CNT_W-1:0];
        end
    end

endmodule

@@ hw/rtl/pmd_index_split.sv @@
// ----------------------------------------------------------------------------
// Flat index and chunk split
// Forms the flat destination index and splits it into a chunk number and an
// offset, over three register stages.
// ----------------------------------------------------------------------------
module pmd_index_split
    import pmd_pkg::*;
#(
    parameter int DIM_W      = 13,
    parameter int CNT_W      = 12,
    parameter int CHUNK_SIZE = 1024
) (
    input  logic               clk,
    input  pmd_stage_en_t      en,
    input  pmd_meta_t          meta_a,
    input  logic [CNT_W-1:0]   dr_a,
    input  logic [CNT_W-1:0]   dc_a,
    input  logic [DIM_W-1:0]   cols,
    output pmd_meta_t          meta_r,
    output logic [CHUNK_W-1:0] chunk_r,
    output logic [OFFS_W-1:0]  offset_r
);

    localparam int FW         = 2 * DIM_W;
    localparam int CW         = $clog2(CHUNK_SIZE);
    localparam int RW         = FW + 17;
    localparam bit CHUNK_POW2 = (CHUNK_SIZE & (CHUNK_SIZE - 1)) == 0;

    logic [FW-1:0]         flat_b;
    logic [FW-1:0]         flat_c;
    logic [FW-1:0]         q_c;
    logic [FW-1:0]         q_next;
    logic [RW-1:0]         rem;
    logic [FW+CHUNK_W-1:0] q_ext;
    pmd_meta_t             meta_b;
    pmd_meta_t             meta_c;

    generate
        if (CHUNK_POW2)
        begin : g_shift
            assign q_next = flat_b >> CW;
        end
        else
        begin : g_recip
            // Quotient by a rounded-up reciprocal; exact for every FW-bit index.
            localparam int S  = FW + CW;
            localparam int MW = S + 1;
            localparam logic [63:0] RECIP =
                ((64'd1 << S) + 64'(CHUNK_SIZE) - 64'd1) / 64'(CHUNK_SIZE);

            logic [FW+MW-1:0] prod;

            assign prod   = (FW+MW)'(flat_b) * (FW+MW)'(RECIP[MW-1:0]);
            assign q_next = prod[S+FW-1:S];
        end
    endgenerate

    assign rem   = RW'(flat_c) - RW'(q_c) * RW'(CHUNK_SIZE);
    assign q_ext = {{CHUNK_W{1'b0}}, q_c};

    always_ff @(posedge clk)
    begin
        if (en.b)
        begin
            flat_b <= FW'(dr_a) * FW'(cols) + FW'(dc_a);
            meta_b <= meta_a;
        end
        if (en.c)
        begin
            flat_c <= flat_b;
            q_c    <= q_next;
            meta_c <= meta_b;
        end
        if (en.r)
        begin
            chunk_r  <= q_ext[CHUNK_W-1:0];
            offset_r <= rem[OFFS_W-1:0];
            meta_r   <= meta_c;
        end
    end

endmodule

@@ hw/rtl/polyphase_matrix_deinterleave.sv @@
// ----------------------------------------------------------------------------
// Polyphase matrix deinterleave
// Address generator for the 2x2 polyphase split of a row-major matrix.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake          Contents
//  din       in         valid / ready      element_bits
//  dout      out        valid / ready      element, dest row/col, chunk, offset, last
//  apb       in         psel/penable/...   row_count, column_count
//
//  One element per cycle sustained while dout is ready. The accepting edge
//  loads the address stage; the transaction then passes the flat index
//  multiply and the chunk quotient stages, and the result register takes the
//  remainder and holds the finished transaction. Every stage holds its item
//  while the next one is full and cannot move on, and takes a new one as soon
//  as it frees up, so bubbles close up under a stalled output. Reset clears
//  the valid bits, the source counters and sets both dimensions to one.
// ----------------------------------------------------------------------------
module polyphase_matrix_deinterleave
    import pmd_pkg::*;
#(
    parameter int MAX_DIM    = 4096,
    parameter int CHUNK_SIZE = 1024
) (
    input  logic                  clk,
    input  logic                  rst_n,
    pmd_in_if.sink                din,
    pmd_out_if.source             dout,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int CNT_W = $clog2(MAX_DIM);

    logic [DIM_W-1:0]   rows;
    logic [DIM_W-1:0]   cols;
    logic               v_a_reg;
    logic               v_b_reg;
    logic               v_c_reg;
    logic               v_r_reg;
    logic               v_a_next;
    logic               v_b_next;
    logic               v_c_next;
    logic               v_r_next;
    pmd_stage_en_t      en;
    logic               accept;
    pmd_meta_t          meta_a;
    pmd_meta_t          meta_r;
    logic [CNT_W-1:0]   dr_a;
    logic [CNT_W-1:0]   dc_a;
    logic [CHUNK_W-1:0] chunk_r;
    logic [OFFS_W-1:0]  offset_r;

    pmd_cfg_regs #(
        .MAX_DIM (MAX_DIM),
        .DIM_W   (DIM_W)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .rows    (rows),
        .cols    (cols)
    );

    // A stage loads when it is empty or its content moves on this cycle.
    always_comb
    begin
        en.r = !v_r_reg || dout.ready;
        en.c = !v_c_reg || en.r;
        en.b = !v_b_reg || en.c;
        en.a = !v_a_reg || en.b;
    end

    assign din.ready = en.a;
    assign accept    = din.valid && en.a;

    always_comb
    begin
        v_a_next = en.a ? din.valid : v_a_reg;
        v_b_next = en.b ? v_a_reg   : v_b_reg;
        v_c_next = en.c ? v_b_reg   : v_c_reg;
        v_r_next = en.r ? v_c_reg   : v_r_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_a_reg <= 1'b0;
            v_b_reg <= 1'b0;
            v_c_reg <= 1'b0;
            v_r_reg <= 1'b0;
        end
        else
        begin
            v_a_reg <= v_a_next;
            v_b_reg <= v_b_next;
            v_c_reg <= v_c_next;
            v_r_reg <= v_r_next;
        end
    end

    pmd_addr_gen #(
        .DIM_W (DIM_W),
        .CNT_W (CNT_W)
    ) u_addr (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .load         (en.a),
        .element_bits (din.element_bits),
        .rows         (rows),
        .cols         (cols),
        .meta_a       (meta_a),
        .dr_a         (dr_a),
        .dc_a         (dc_a)
    );

    pmd_index_split #(
        .DIM_W      (DIM_W),
        .CNT_W      (CNT_W),
        .CHUNK_SIZE (CHUNK_SIZE)
    ) u_split (
        .clk      (clk),
        .en       (en),
        .meta_a   (meta_a),
        .dr_a     (dr_a),
        .dc_a     (dc_a),
        .cols     (cols),
        .meta_r   (meta_r),
        .chunk_r  (chunk_r),
        .offset_r (offset_r)
    );

    assign dout.valid         = v_r_reg;
    assign dout.element_out   = meta_r.element;
    assign dout.dest_row      = meta_r.dest_row;
    assign dout.dest_col      = meta_r.dest_col;
    assign dout.dest_chunk    = chunk_r;
    assign dout.dest_offset   = offset_r;
    assign dout.end_of_matrix = meta_r.end_of_matrix;

`ifndef SYNTHESIS
    a_accept_fills_a: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> v_a_reg)
        else $error("accepted transaction did not reach the address stage");

    a_a_moves_to_b: assert property (@(posedge clk) disable iff (!rst_n)
        v_a_reg && en.b |=> v_b_reg)
        else $error("address stage content lost on its way to the index stage");

    a_c_moves_to_r: assert property (@(posedge clk) disable iff (!rst_n)
        v_c_reg && en.r |=> v_r_reg)
        else $error("quotient stage content lost on its way to the result register");
`endif

endmodule
